/* sv/depth_profile_interpolator_macros.svh */
// Assertion macros used by the depth profile interpolator controller.
// In synthesis the macros expand to nothing.
`ifndef DEPTH_PROFILE_INTERPOLATOR_MACROS_SVH
`define DEPTH_PROFILE_INTERPOLATOR_MACROS_SVH
`ifndef SYNTHESIS
// Checked on every rising edge outside reset.
`define DPI_ASSERT(lbl, clk, rst, prop, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) prop) else $error(msg);
// Checked on every rising edge, reset included.
`define DPI_ASSERT_ALWAYS(lbl, clk, prop, msg) \
   lbl: assert property (@(posedge clk) prop) else $error(msg);
`else
`define DPI_ASSERT(lbl, clk, rst, prop, msg)
`define DPI_ASSERT_ALWAYS(lbl, clk, prop, msg)
`endif
`endif

/* sv/dpi_pkg.sv */
package dpi_pkg;

   // Fixed field widths of the request, response and register ports.
   localparam int OP_W     = 2;
   localparam int PI_W     = 6;
   localparam int ISO_W    = 4;
   localparam int CONC_W   = 17;
   localparam int PTS_W    = 7;
   localparam int ISOS_W   = 5;
   localparam int CSR_IDX_W = 1;
   localparam int CSR_DAT_W = 7;

   localparam logic [CONC_W-1:0] CONC_ONE = 17'd65536;

   // Operation codes.
   localparam logic [OP_W-1:0] OP_WR_DEPTH = 2'd0;
   localparam logic [OP_W-1:0] OP_WR_CONC  = 2'd1;
   localparam logic [OP_W-1:0] OP_QUERY    = 2'd2;

   // Register indexes.
   localparam logic [CSR_IDX_W-1:0] CFG_POINTS   = 1'b0;
   localparam logic [CSR_IDX_W-1:0] CFG_ISOTOPES = 1'b1;

   // Commands from the controller to the datapath.
   typedef struct packed {
      logic accept;     // item taken this cycle
      logic rd_x0;      // read the first breakpoint depth
      logic ld_x0;      // capture the first breakpoint depth
      logic compare;    // compare the query depth with the next breakpoint
      logic ld_c0;      // capture the left concentration, read the right one
      logic ld_c1;      // capture the right concentration
      logic ld_abs;     // form signs and magnitudes
      logic ld_prod;    // register the product and load the divider
      logic div_step;   // one quotient bit
      logic finish;     // register the response fields
   } dpi_cmd_type;

   // Status from the datapath to the controller.
   typedef struct packed {
      logic is_query;   // the offered item is a query
      logic less;       // query depth lies below the breakpoint just read
      logic at_last;    // the breakpoint just read is the last one in use
      logic past;       // the query lies at or beyond the last breakpoint
      logic div_last;   // the divider works on its final bit
   } dpi_status_type;

endpackage

/* sv/dpi_ctrl.sv */
module dpi_ctrl
   import dpi_pkg::*;
(
   input  logic           clock,
   input  logic           reset,
   input  logic           start,
   output logic           busy,
   output logic           rsp_valid,
   input  dpi_status_type status,
   output dpi_cmd_type    cmd
);

`include "depth_profile_interpolator_macros.svh"

   localparam logic [3:0] S_IDLE = 4'd0;
   localparam logic [3:0] S_X0   = 4'd1;
   localparam logic [3:0] S_X0W  = 4'd2;
   localparam logic [3:0] S_RD   = 4'd3;
   localparam logic [3:0] S_CMP  = 4'd4;
   localparam logic [3:0] S_C0   = 4'd5;
   localparam logic [3:0] S_C0W  = 4'd6;
   localparam logic [3:0] S_C1W  = 4'd7;
   localparam logic [3:0] S_MUL  = 4'd8;
   localparam logic [3:0] S_PROD = 4'd9;
   localparam logic [3:0] S_DIV  = 4'd10;
   localparam logic [3:0] S_FIN  = 4'd11;

   logic [3:0] state_ff;
   logic [3:0] state_in;
   logic       valid_ff;
   logic       valid_in;

   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         S_IDLE: begin
            if (start && status.is_query) state_in = S_X0;
         end
         S_X0:   state_in = S_X0W;
         S_X0W:  state_in = S_RD;
         S_RD:   state_in = S_CMP;
         S_CMP: begin
            if (status.less || status.at_last) state_in = S_C0;
            else state_in = S_RD;
         end
         S_C0:   state_in = S_C0W;
         S_C0W: begin
            if (status.past) state_in = S_FIN;
            else state_in = S_C1W;
         end
         S_C1W:  state_in = S_MUL;
         S_MUL:  state_in = S_PROD;
         S_PROD: state_in = S_DIV;
         S_DIV: begin
            if (status.div_last) state_in = S_FIN;
         end
         S_FIN:  state_in = S_IDLE;
         default: state_in = S_IDLE;
      endcase
   end

   assign valid_in = (state_ff == S_FIN);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= S_IDLE;
         valid_ff <= 1'b0;
      end else begin
         state_ff <= state_in;
         valid_ff <= valid_in;
      end
   end

   assign busy      = (state_ff != S_IDLE);
   assign rsp_valid = valid_ff;

   always_comb begin
      cmd          = '0;
      cmd.accept   = start && (state_ff == S_IDLE);
      cmd.rd_x0    = (state_ff == S_X0);
      cmd.ld_x0    = (state_ff == S_X0W);
      cmd.compare  = (state_ff == S_CMP);
      cmd.ld_c0    = (state_ff == S_C0W);
      cmd.ld_c1    = (state_ff == S_C1W);
      cmd.ld_abs   = (state_ff == S_MUL);
      cmd.ld_prod  = (state_ff == S_PROD);
      cmd.div_step = (state_ff == S_DIV);
      cmd.finish   = (state_ff == S_FIN);
   end

   `DPI_ASSERT(a_query_starts, clock, reset, (cmd.accept && status.is_query) |=> (state_ff == S_X0), "accepted query did not start the search")
   `DPI_ASSERT(a_write_no_busy, clock, reset, (cmd.accept && !status.is_query) |=> !busy, "write item left the block busy")
   `DPI_ASSERT(a_single_strobe, clock, reset, rsp_valid |=> !rsp_valid, "result strobe lasted more than one cycle")
   `DPI_ASSERT(a_div_to_result, clock, reset, (state_ff == S_DIV && status.div_last) |=> ##1 rsp_valid, "last divider step gave no result")
   `DPI_ASSERT_ALWAYS(a_reset_idle, clock, reset |=> (!busy && !rsp_valid), "reset did not return the block to idle")

endmodule

/* sv/dpi_datapath.sv */
module dpi_datapath
   import dpi_pkg::*;
#(
   parameter int MAX_POINTS   = 64,
   parameter int MAX_ISOTOPES = 16,
   parameter int DEPTH_BITS   = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  dpi_cmd_type           cmd,
   output dpi_status_type        status,
   input  logic [OP_W-1:0]       req_operation,
   input  logic [PI_W-1:0]       req_point_index,
   input  logic [ISO_W-1:0]      req_isotope_index,
   input  logic [DEPTH_BITS-1:0] req_depth_value,
   input  logic [CONC_W-1:0]     req_conc_value,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DAT_W-1:0]  csr_data,
   output logic [PI_W-1:0]       rsp_segment_found,
   output logic [DEPTH_BITS-1:0] rsp_used_depth,
   output logic [CONC_W-1:0]     rsp_concentration,
   output logic                  rsp_past_end
);

   localparam int PA_W   = $clog2(MAX_POINTS);
   localparam int CA_W   = $clog2(MAX_POINTS * MAX_ISOTOPES);
   localparam int PROD_W = CONC_W + DEPTH_BITS;
   localparam int DCNT_W = $clog2(PROD_W);

   // Configuration registers.
   logic [PTS_W-1:0]  points_ff;
   logic [ISOS_W-1:0] isos_ff;

   // Tables.
   logic [DEPTH_BITS-1:0] depth_mem [MAX_POINTS];
   logic [CONC_W-1:0]     conc_mem  [MAX_POINTS * MAX_ISOTOPES];
   logic [DEPTH_BITS-1:0] depth_rd_ff;
   logic [CONC_W-1:0]     conc_rd_ff;

   // Query state.
   logic [DEPTH_BITS-1:0] dv_ff;
   logic [ISO_W-1:0]      iso_ff;
   logic [PA_W-1:0]       seg_ff;
   logic                  past_ff;
   logic [DEPTH_BITS-1:0] x0_ff;
   logic [DEPTH_BITS-1:0] x1_ff;
   logic [CONC_W-1:0]     c0_ff;
   logic [CONC_W-1:0]     c1_ff;
   logic                  neg_ff;
   logic                  zw_ff;
   logic [CONC_W-1:0]     adc_ff;
   logic [DEPTH_BITS-1:0] adx_ff;
   logic [DEPTH_BITS-1:0] aw_ff;
   logic [PROD_W-1:0]     dvd_ff;
   logic [DEPTH_BITS-1:0] rem_ff;
   logic [DCNT_W-1:0]     dcnt_ff;

   // Response registers.
   logic [PI_W-1:0]       seg_out_ff;
   logic [DEPTH_BITS-1:0] used_out_ff;
   logic [CONC_W-1:0]     conc_out_ff;
   logic                  past_out_ff;

   logic [ISO_W-1:0]      iso_sel;
   logic [PA_W-1:0]       wr_pt;
   logic [CA_W-1:0]       wr_caddr;
   logic [CONC_W-1:0]     wr_cv;
   logic                  wr_depth;
   logic                  wr_conc;
   logic [PA_W-1:0]       eff_last;
   logic [PA_W-1:0]       seg_p1;
   logic [PA_W-1:0]       depth_raddr;
   logic [CA_W-1:0]       c0_addr;
   logic [CA_W-1:0]       c1_addr;
   logic [CA_W-1:0]       conc_raddr;
   logic                  ndc;
   logic                  ndx;
   logic                  nw;
   logic [DEPTH_BITS:0]   rem_sh;
   logic [DEPTH_BITS:0]   rem_dif;
   logic                  rem_ge;
   logic [PROD_W:0]       pos_sum;
   logic                  iso_ok;
   logic [CONC_W-1:0]     conc_calc;

   // Request decode and table writes.
   assign iso_sel  = (int'(req_isotope_index) < MAX_ISOTOPES) ? req_isotope_index : '0;
   assign wr_pt    = PA_W'(req_point_index);
   assign wr_caddr = CA_W'(wr_pt) * CA_W'(MAX_ISOTOPES) + CA_W'(req_isotope_index);
   assign wr_cv    = (req_conc_value > CONC_ONE) ? CONC_ONE : req_conc_value;
   assign wr_depth = cmd.accept && (req_operation == OP_WR_DEPTH)
                     && (int'(req_point_index) < MAX_POINTS);
   assign wr_conc  = cmd.accept && (req_operation == OP_WR_CONC)
                     && (int'(req_point_index) < MAX_POINTS)
                     && (int'(req_isotope_index) < MAX_ISOTOPES);

   always_ff @(posedge clock) begin
      if (wr_depth) depth_mem[wr_pt] <= req_depth_value;
      depth_rd_ff <= depth_mem[depth_raddr];
   end

   always_ff @(posedge clock) begin
      if (wr_conc) conc_mem[wr_caddr] <= wr_cv;
      conc_rd_ff <= conc_mem[conc_raddr];
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         points_ff <= PTS_W'(2);
         isos_ff   <= ISOS_W'(1);
      end else if (csr_write) begin
         unique case (csr_index)
            CFG_POINTS:   points_ff <= csr_data[PTS_W-1:0];
            CFG_ISOTOPES: isos_ff   <= csr_data[ISOS_W-1:0];
            default: ;
         endcase
      end
   end

   // Index of the last breakpoint in use, with the register clamped to range.
   always_comb begin
      priority if (points_ff < PTS_W'(2)) eff_last = PA_W'(1);
      else if (int'(points_ff) > MAX_POINTS) eff_last = PA_W'(MAX_POINTS - 1);
      else eff_last = PA_W'(points_ff - PTS_W'(1));
   end

   assign seg_p1      = seg_ff + PA_W'(1);
   assign depth_raddr = cmd.rd_x0 ? seg_ff : seg_p1;
   assign c0_addr     = CA_W'(seg_ff) * CA_W'(MAX_ISOTOPES) + CA_W'(iso_ff);
   assign c1_addr     = CA_W'(seg_p1) * CA_W'(MAX_ISOTOPES) + CA_W'(iso_ff);
   assign conc_raddr  = cmd.ld_c0 ? c1_addr : c0_addr;

   assign status.is_query = (req_operation == OP_QUERY);
   assign status.less     = (dv_ff < depth_rd_ff);
   assign status.at_last  = (seg_p1 == eff_last);
   assign status.past     = past_ff;
   assign status.div_last = (dcnt_ff == DCNT_W'(PROD_W - 1));

   // Breakpoint search.
   always_ff @(posedge clock) begin
      if (cmd.accept && status.is_query) begin
         dv_ff   <= req_depth_value;
         iso_ff  <= iso_sel;
         seg_ff  <= '0;
         past_ff <= 1'b0;
      end
      if (cmd.ld_x0) x0_ff <= depth_rd_ff;
      if (cmd.compare) begin
         if (status.less) begin
            x1_ff <= depth_rd_ff;
         end else begin
            x0_ff   <= depth_rd_ff;
            seg_ff  <= seg_p1;
            past_ff <= status.at_last;
         end
      end
      if (cmd.ld_c0) c0_ff <= conc_rd_ff;
      if (cmd.ld_c1) c1_ff <= conc_rd_ff;
   end

   // Signs and magnitudes of the slope terms.
   assign ndc = (c1_ff < c0_ff);
   assign ndx = (dv_ff < x0_ff);
   assign nw  = (x1_ff < x0_ff);

   always_ff @(posedge clock) begin
      if (cmd.ld_abs) begin
         neg_ff <= ndc ^ ndx ^ nw;
         zw_ff  <= (x1_ff == x0_ff);
         adc_ff <= ndc ? (c0_ff - c1_ff) : (c1_ff - c0_ff);
         adx_ff <= ndx ? (x0_ff - dv_ff) : (dv_ff - x0_ff);
         aw_ff  <= nw ? (x0_ff - x1_ff) : (x1_ff - x0_ff);
      end
   end

   // Restoring divider, one quotient bit per cycle; the dividend register
   // fills with the quotient as it shifts out.
   assign rem_sh  = {rem_ff, dvd_ff[PROD_W-1]};
   assign rem_dif = rem_sh - {1'b0, aw_ff};
   assign rem_ge  = (rem_sh >= {1'b0, aw_ff});

   always_ff @(posedge clock) begin
      if (cmd.ld_prod) begin
         dvd_ff  <= PROD_W'(adc_ff) * PROD_W'(adx_ff);
         rem_ff  <= '0;
         dcnt_ff <= '0;
      end else if (cmd.div_step) begin
         rem_ff  <= rem_ge ? rem_dif[DEPTH_BITS-1:0] : rem_sh[DEPTH_BITS-1:0];
         dvd_ff  <= {dvd_ff[PROD_W-2:0], rem_ge};
         dcnt_ff <= dcnt_ff + DCNT_W'(1);
      end
   end

   // Final value with saturation to zero..one; zero for an isotope beyond the configured count.
   assign pos_sum = {1'b0, dvd_ff} + (PROD_W + 1)'(c0_ff);
   assign iso_ok  = (iso_ff == '0) || ({1'b0, iso_ff} < isos_ff);

   always_comb begin
      priority if (past_ff || zw_ff) conc_calc = c0_ff;
      else if (neg_ff) begin
         conc_calc = (dvd_ff >= PROD_W'(c0_ff)) ? '0 : (c0_ff - dvd_ff[CONC_W-1:0]);
      end else begin
         conc_calc = (pos_sum > (PROD_W + 1)'(CONC_ONE)) ? CONC_ONE
                                                         : pos_sum[CONC_W-1:0];
      end
      if (!iso_ok) conc_calc = '0;
   end

   always_ff @(posedge clock) begin
      if (cmd.finish) begin
         seg_out_ff  <= PI_W'(seg_ff);
         used_out_ff <= past_ff ? x0_ff : dv_ff;
         conc_out_ff <= conc_calc;
         past_out_ff <= past_ff;
      end
   end

   assign rsp_segment_found = seg_out_ff;
   assign rsp_used_depth    = used_out_ff;
   assign rsp_concentration = conc_out_ff;
   assign rsp_past_end      = past_out_ff;

endmodule

/* sv/depth_profile_interpolator.sv */
// Write items are taken only while idle and leave busy low; a query holds busy
// while it compares at most points_in_use-1 breakpoints, one read and one compare
// each, and, unless the query lies past the end, while the bit-serial divider runs.
// The result strobes in the same cycle as busy falls; the receiver cannot stall.
// Synchronous active-high reset idles control and presets the configuration registers;
// tables and the query and response registers are not cleared.
module depth_profile_interpolator
   import dpi_pkg::*;
#(
   parameter int MAX_POINTS   = 64,
   parameter int MAX_ISOTOPES = 16,
   parameter int DEPTH_BITS   = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   output logic                  busy,
   input  logic [OP_W-1:0]       req_operation,
   input  logic [PI_W-1:0]       req_point_index,
   input  logic [ISO_W-1:0]      req_isotope_index,
   input  logic [DEPTH_BITS-1:0] req_depth_value,
   input  logic [CONC_W-1:0]     req_conc_value,
   output logic                  rsp_valid,
   output logic [PI_W-1:0]       rsp_segment_found,
   output logic [DEPTH_BITS-1:0] rsp_used_depth,
   output logic [CONC_W-1:0]     rsp_concentration,
   output logic                  rsp_past_end,
   input  logic                  csr_write,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DAT_W-1:0]  csr_data
);

   // The controller sequences one query at a time: it reads the first
   // breakpoint, then walks the breakpoints one read and one compare at a
   // time until the query depth lies below one of them or the last point in
   // use is reached. It fetches the segment's left concentration; unless the query
   // lies past the end it also fetches the right one, forms the slope magnitudes,
   // multiplies once and divides one quotient bit per cycle; the result is registered.
   dpi_cmd_type    cmd;
   dpi_status_type status;

   dpi_ctrl u_ctrl (
      .clock     (clock),
      .reset     (reset),
      .start     (start),
      .busy      (busy),
      .rsp_valid (rsp_valid),
      .status    (status),
      .cmd       (cmd)
   );

   // The datapath holds the breakpoint and concentration tables, the two
   // configuration registers, the search counter, the multiplier and the
   // divider. Table writes happen at the edge that accepts a write item,
   // so they never occupy the controller.
   dpi_datapath #(
      .MAX_POINTS   (MAX_POINTS),
      .MAX_ISOTOPES (MAX_ISOTOPES),
      .DEPTH_BITS   (DEPTH_BITS)
   ) u_datapath (
      .clock             (clock),
      .reset             (reset),
      .cmd               (cmd),
      .status            (status),
      .req_operation     (req_operation),
      .req_point_index   (req_point_index),
      .req_isotope_index (req_isotope_index),
      .req_depth_value   (req_depth_value),
      .req_conc_value    (req_conc_value),
      .csr_write         (csr_write),
      .csr_index         (csr_index),
      .csr_data          (csr_data),
      .rsp_segment_found (rsp_segment_found),
      .rsp_used_depth    (rsp_used_depth),
      .rsp_concentration (rsp_concentration),
      .rsp_past_end      (rsp_past_end)
   );

endmodule
